// ===== design/tlb_page_table_translator_top_defines.svh =====
// Assertion macros used by the translator's top-level RTL file.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbpt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLBPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbpt: next-cycle check failed");

`endif

// ===== design/tlbpt_pkg.sv =====
// Shared types and constants of the address translator.
// No dependencies; used by every module of the block.
`default_nettype none

package tlbpt_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 8;

    localparam int ADDR_W      = 16;
    localparam int TAG_W       = 8;
    localparam int FRAME_W     = 8;
    localparam int FREE_W      = 9;
    localparam int COUNT_W     = 32;
    localparam int OUT_DATA_W  = 88;

    localparam logic [FREE_W-1:0] FREE_LIMIT = 9'd256;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Broadcast to every TLB cell.
    typedef struct packed {
        logic commit;
        logic any_hit;
        logic full;
    } cell_ctrl_t;

    typedef struct packed {
        logic             en;
        logic [TAG_W-1:0] page;
    } pt_rd_t;

    typedef struct packed {
        logic               en;
        logic [TAG_W-1:0]   page;
        logic [FRAME_W-1:0] frame;
    } pt_wr_t;

endpackage

`default_nettype wire

// ===== design/tlbpt_cell.sv =====
// One TLB entry in the LRU chain: position 0 is least recent.
// Depends on tlbpt_pkg; instantiated in a row by the top level.
`default_nettype none

module tlbpt_cell
    import tlbpt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [TAG_W-1:0]   page,
    input  wire logic [FRAME_W-1:0] new_frame,
    input  wire logic               prev_valid,
    input  wire logic               next_valid,
    input  wire logic [TAG_W-1:0]   next_tag,
    input  wire logic [FRAME_W-1:0] next_frame,
    input  wire logic               hit_in,
    input  wire logic [FRAME_W-1:0] frame_in,
    output logic                    valid,
    output logic [TAG_W-1:0]        tag,
    output logic [FRAME_W-1:0]      frame,
    output logic                    hit_out,
    output logic [FRAME_W-1:0]      frame_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic               match;
    logic               shift;
    logic               take_neighbour;
    logic               is_top;
    logic               is_first_free;
    logic               load_new;

    assign match     = valid_reg && (tag_reg == page);
    assign hit_out   = hit_in || match;
    assign frame_out = match ? frame_reg : frame_in;

    // On a hit every entry from the hit upward moves down one place; on a miss
    // into a full TLB the whole row moves and the oldest entry drops out.
    assign shift          = ctrl.commit && (ctrl.any_hit ? hit_out : ctrl.full);
    assign take_neighbour = shift && next_valid;

    assign is_top        = valid_reg && !next_valid;
    assign is_first_free = !valid_reg && prev_valid;
    assign load_new      = ctrl.commit &&
                           ((ctrl.any_hit || ctrl.full) ? is_top : is_first_free);

    always_comb
    begin
        valid_next = valid_reg || load_new;
        tag_next   = tag_reg;
        frame_next = frame_reg;
        if (take_neighbour)
        begin
            tag_next   = next_tag;
            frame_next = next_frame;
        end
        else if (load_new)
        begin
            tag_next   = page;
            frame_next = new_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        frame_reg <= frame_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign frame = frame_reg;

endmodule

`default_nettype wire

// ===== design/tlbpt_page_table.sv =====
// Page table: mapped flags in flip-flops and a frame memory with a registered read.
// Depends on tlbpt_pkg.
`default_nettype none

module tlbpt_page_table
    import tlbpt_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pt_rd_t        rd,
    input  wire pt_wr_t        wr,
    output logic               rd_mapped,
    output logic [FRAME_W-1:0] rd_frame
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);

    logic [PAGE_COUNT-1:0] mapped_reg;
    logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
    logic                  rd_mapped_reg;
    logic [FRAME_W-1:0]    rd_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg    <= '0;
            rd_mapped_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                mapped_reg[wr.page[PAGE_W-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_mapped_reg <= mapped_reg[rd.page[PAGE_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            frame_mem[wr.page[PAGE_W-1:0]] <= wr.frame;
        end
        if (rd.en)
        begin
            rd_frame_reg <= frame_mem[rd.page[PAGE_W-1:0]];
        end
    end

    assign rd_mapped = rd_mapped_reg;
    assign rd_frame  = rd_frame_reg;

endmodule

`default_nettype wire

// ===== design/tlb_page_table_translator_top.sv =====
// Address translator: an accepted address waits in ST_LOOKUP until its result is
// committed to the output register, and no new address is taken before that:
// the page-table read is registered, then the TLB row and the tables update.
// A stalled output holds the lookup; the next address is taken while a finished
// result still waits. Reset clears the TLB valid bits, the page-table mapped
// flags, the free-frame pointer and the totals at once; no clearing pass.
`default_nettype none

`include "tlb_page_table_translator_top_defines.svh"

module tlb_page_table_translator_top
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ADDR_W-1:0]     s_tdata,  // [15:0] logical_address
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] phys_addr, [16] tlb_hit, [17] page_fault,
    // [49:18] hit_count, [81:50] fault_count, [87:82] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int SRC_W  = ADDR_W - OFFSET_BITS;
    localparam int RED_W  = SRC_W + TAG_W;
    localparam int WIDE_W = FRAME_W + OFFSET_BITS;

    // Page number modulo the table size by shifted compare and subtract;
    // the quotient never exceeds eight bits.
    function automatic logic [TAG_W-1:0] page_of(input logic [ADDR_W-1:0] addr);
        logic [RED_W-1:0] rem;
        logic [RED_W-1:0] step;
        rem = RED_W'(addr[ADDR_W-1:OFFSET_BITS]);
        for (int k = TAG_W - 1; k >= 0; k--)
        begin
            step = RED_W'(PAGE_COUNT) << k;
            if (rem >= step)
            begin
                rem = rem - step;
            end
        end
        return rem[TAG_W-1:0];
    endfunction

    state_t                   state_reg;
    state_t                   state_next;
    logic [TAG_W-1:0]         page_reg;
    logic [OFFSET_BITS-1:0]   offset_reg;
    logic [FREE_W-1:0]        free_reg;
    logic [FREE_W-1:0]        free_next;
    logic [COUNT_W-1:0]       hit_total_reg;
    logic [COUNT_W-1:0]       hit_total_next;
    logic [COUNT_W-1:0]       fault_total_reg;
    logic [COUNT_W-1:0]       fault_total_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_next;

    logic                     in_accept;
    logic                     out_free;
    logic                     commit;
    logic                     hit;
    logic                     fault;
    logic [FRAME_W-1:0]       frame;
    logic [WIDE_W-1:0]        phys_wide;
    logic [ADDR_W-1:0]        phys;
    logic                     rd_mapped;
    logic [FRAME_W-1:0]       rd_frame;
    pt_rd_t                   pt_rd;
    pt_wr_t                   pt_wr;
    cell_ctrl_t               ctrl;

    logic [TLB_ENTRIES-1:0]   valid_vec;
    logic [TAG_W-1:0]         tag_w   [TLB_ENTRIES];
    logic [FRAME_W-1:0]       frame_w [TLB_ENTRIES];
    logic [TLB_ENTRIES:0]     hit_chain;
    logic [FRAME_W-1:0]       frame_chain [TLB_ENTRIES+1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_LOOKUP:
            begin
                commit = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign pt_rd.en   = in_accept;
    assign pt_rd.page = page_of(s_tdata);

    tlbpt_page_table #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_page_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (pt_rd),
        .wr        (pt_wr),
        .rd_mapped (rd_mapped),
        .rd_frame  (rd_frame)
    );

    assign hit_chain[0]   = 1'b0;
    assign frame_chain[0] = '0;

    assign ctrl.commit  = commit;
    assign ctrl.any_hit = hit_chain[TLB_ENTRIES];
    assign ctrl.full    = valid_vec[TLB_ENTRIES-1];

    for (genvar i = 0; i < TLB_ENTRIES; i++)
    begin : g_cell
        logic               prev_valid;
        logic               next_valid;
        logic [TAG_W-1:0]   next_tag;
        logic [FRAME_W-1:0] next_frame;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_inner_prev
            assign prev_valid = valid_vec[i-1];
        end

        if (i == TLB_ENTRIES - 1)
        begin : g_last
            assign next_valid = 1'b0;
            assign next_tag   = '0;
            assign next_frame = '0;
        end
        else
        begin : g_inner_next
            assign next_valid = valid_vec[i+1];
            assign next_tag   = tag_w[i+1];
            assign next_frame = frame_w[i+1];
        end

        tlbpt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .page       (page_reg),
            .new_frame  (frame),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .next_tag   (next_tag),
            .next_frame (next_frame),
            .hit_in     (hit_chain[i]),
            .frame_in   (frame_chain[i]),
            .valid      (valid_vec[i]),
            .tag        (tag_w[i]),
            .frame      (frame_w[i]),
            .hit_out    (hit_chain[i+1]),
            .frame_out  (frame_chain[i+1])
        );
    end

    assign hit   = hit_chain[TLB_ENTRIES];
    assign fault = !hit && !rd_mapped;

    always_comb
    begin
        if (hit)
        begin
            frame = frame_chain[TLB_ENTRIES];
        end
        else if (rd_mapped)
        begin
            frame = rd_frame;
        end
        else
        begin
            frame = free_reg[FRAME_W-1:0];
        end
    end

    assign pt_wr.en    = commit && fault;
    assign pt_wr.page  = page_reg;
    assign pt_wr.frame = frame;

    always_comb
    begin
        free_next        = free_reg;
        hit_total_next   = hit_total_reg;
        fault_total_next = fault_total_reg;
        if (commit && fault && (free_reg < FREE_LIMIT))
        begin
            free_next = free_reg + 1'b1;
        end
        if (commit && hit && (hit_total_reg != '1))
        begin
            hit_total_next = hit_total_reg + 1'b1;
        end
        if (commit && fault && (fault_total_reg != '1))
        begin
            fault_total_next = fault_total_reg + 1'b1;
        end
    end

    // Frame bits pushed above the address width are dropped.
    assign phys_wide = {frame, offset_reg};
    assign phys      = ADDR_W'(phys_wide);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (commit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_W'({fault_total_next, hit_total_next,
                                         fault, hit, phys});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            free_reg        <= '0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            free_reg        <= free_next;
            hit_total_reg   <= hit_total_next;
            fault_total_reg <= fault_total_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            page_reg   <= pt_rd.page;
            offset_reg <= s_tdata[OFFSET_BITS-1:0];
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Valid entries always form an unbroken run from the least-recent end.
    `TLBPT_ASSERT_SAME(a_valid_packed, 1'b1, ((valid_vec & (valid_vec + 1'b1)) == '0))
    // A completed lookup always leaves a result in the output register.
    `TLBPT_ASSERT_NEXT(a_commit_result, commit, m_tvalid)
    // An accepted transaction always moves on to the lookup.
    `TLBPT_ASSERT_NEXT(a_accept_lookup, in_accept, (state_reg == ST_LOOKUP))

endmodule

`default_nettype wire

// ===== dv/tlb_page_table_translator_top_tb.sv =====
// Self-checking testbench for the TLB and page-table address translator.
// Depends on tlbpt_pkg and tlb_page_table_translator_top; predicts every
// translation in-bench and checks each output transaction against it.
`timescale 1ns / 100ps

module tlb_page_table_translator_top_tb;
    import tlbpt_pkg::*;

    localparam int STALL_MAX   = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // Result fields, lowest bits last so that the cast matches m_tdata.
    typedef struct packed {
        logic [COUNT_W-1:0] fault_count;
        logic [COUNT_W-1:0] hit_count;
        logic               page_fault;
        logic               tlb_hit;
        logic [ADDR_W-1:0]  phys_addr;
    } translation_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Translator state as the testbench sees it; index 0 is least recent.
    logic [TAG_W-1:0]   lru_pages[$];
    logic [FRAME_W-1:0] lru_frames[$];
    bit                 page_present[PAGE_COUNT_DEF];
    logic [FRAME_W-1:0] frame_of_page[PAGE_COUNT_DEF];
    logic [FREE_W-1:0]  free_frame;
    logic [COUNT_W-1:0] hits_so_far;
    logic [COUNT_W-1:0] faults_so_far;

    translation_t pending_translations[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  sender_no_gaps = 1'b0;
    bit  receiver_no_stalls = 1'b0;
    int  long_hold_cycles = 0;

    tlb_page_table_translator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_wait(input bit no_gaps);
        return no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    // Works out the translation of one address and advances the copy of the
    // TLB order, the page table, the free-frame pointer and the totals.
    function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
        translation_t       res;
        logic [TAG_W-1:0]   page;
        logic [FRAME_W-1:0] frame;
        bit                 hit;
        bit                 fault;
        int                 hit_pos;
        page    = addr[ADDR_W-1:OFFSET_BITS_DEF];
        frame   = '0;
        hit     = 1'b0;
        fault   = 1'b0;
        hit_pos = -1;
        for (int i = 0; i < lru_pages.size(); i++)
        begin
            if (hit_pos < 0 && lru_pages[i] == page)
                hit_pos = i;
        end
        if (hit_pos >= 0)
        begin
            hit   = 1'b1;
            frame = lru_frames[hit_pos];
            lru_pages.delete(hit_pos);
            lru_frames.delete(hit_pos);
        end
        if (!hit)
        begin
            if (page_present[page])
                frame = frame_of_page[page];
            else
            begin
                fault = 1'b1;
                frame = free_frame[FRAME_W-1:0];
                if (free_frame < FREE_LIMIT)
                    free_frame = free_frame + 1'b1;
                frame_of_page[page] = frame;
                page_present[page]  = 1'b1;
            end
            if (lru_pages.size() >= TLB_ENTRIES_DEF)
            begin
                lru_pages.delete(0);
                lru_frames.delete(0);
            end
        end
        lru_pages.insert(lru_pages.size(), page);
        lru_frames.insert(lru_frames.size(), frame);
        if (hit && hits_so_far != '1)
            hits_so_far = hits_so_far + 1'b1;
        if (fault && faults_so_far != '1)
            faults_so_far = faults_so_far + 1'b1;
        res.phys_addr   = {frame, addr[OFFSET_BITS_DEF-1:0]};
        res.tlb_hit     = hit;
        res.page_fault  = fault;
        res.hit_count   = hits_so_far;
        res.fault_count = faults_so_far;
        return res;
    endfunction

    task automatic record_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
    endtask

    task automatic check_translation(input translation_t seen);
        translation_t want;
        if (pending_translations.size() == 0)
        begin
            record_mismatch("unexpected transaction", '0, seen.phys_addr);
            return;
        end
        want = pending_translations.pop_front();
        if (seen.phys_addr !== want.phys_addr)
            record_mismatch("phys_addr", want.phys_addr, seen.phys_addr);
        if (seen.tlb_hit !== want.tlb_hit)
            record_mismatch("tlb_hit", want.tlb_hit, seen.tlb_hit);
        if (seen.page_fault !== want.page_fault)
            record_mismatch("page_fault", want.page_fault, seen.page_fault);
        if (seen.hit_count !== want.hit_count)
            record_mismatch("hit_count", want.hit_count, seen.hit_count);
        if (seen.fault_count !== want.fault_count)
            record_mismatch("fault_count", want.fault_count, seen.fault_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_translation(translation_t'(m_tdata[$bits(translation_t)-1:0]));
    end

    // Output side: a random stall before each transaction, unless a test turns
    // stalls off, or a long hold-off when a test asks for one.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                stall = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
                stall = draw_wait(receiver_no_stalls);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Offers one address and predicts its translation once it is accepted.
    // The valid stays high across back-to-back transactions.
    task automatic offer_address(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = draw_wait(sender_no_gaps);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        pending_translations.insert(pending_translations.size(),
                                    translate_address(addr));
    endtask

    task automatic test_field_extremes();
        offer_address(16'h0000);
        offer_address(16'hFFFF);
        offer_address(16'h00FF);
        offer_address(16'hFF00);
        offer_address(16'hAA55);
        offer_address(16'h55AA);
    endtask

    // Seventeen new pages push the oldest out; revisiting one that was
    // evicted is a miss on a mapped page, so no new frame is taken.
    task automatic test_lru_eviction();
        for (int p = 1; p <= TLB_ENTRIES_DEF + 1; p++)
            offer_address({p[TAG_W-1:0], 8'h3C});
        offer_address(16'h0011);
        offer_address(16'h1122);
        offer_address(16'h1133);
    endtask

    // Touches every page once in shuffled order, so the page table fills
    // and the free-frame pointer reaches its limit.
    task automatic test_page_table_fill();
        int order[PAGE_COUNT_DEF];
        int j;
        int swap;
        foreach (order[i])
            order[i] = i;
        for (int i = PAGE_COUNT_DEF - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        foreach (order[i])
            offer_address({order[i][TAG_W-1:0], 8'($urandom)});
    endtask

    task automatic test_output_backpressure();
        sender_no_gaps = 1'b1;
        receiver_no_stalls = 1'b1;
        long_hold_cycles = 300;
        for (int i = 0; i < 60; i++)
            offer_address({4'h0, 4'($urandom_range(0, 11)), 8'($urandom)});
        sender_no_gaps = 1'b0;
        receiver_no_stalls = 1'b0;
    endtask

    // Mostly a drifting working set around the TLB size, so hits, misses and
    // evictions all come often; the rest are addresses drawn at random.
    task automatic test_random_locality(input int count);
        logic [TAG_W-1:0] base;
        int               span;
        logic [TAG_W-1:0] page;
        base = '0;
        span = 1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                sender_no_gaps     = ($urandom_range(0, 3) == 0);
                receiver_no_stalls = ($urandom_range(0, 3) == 0);
            end
            if (i % 40 == 0)
            begin
                base = 8'($urandom);
                span = $urandom_range(4, 28);
            end
            if ($urandom_range(0, 99) < 15)
                offer_address(16'($urandom));
            else
            begin
                page = base + 8'($urandom_range(0, span - 1));
                offer_address({page, 8'($urandom)});
            end
        end
        sender_no_gaps = 1'b0;
        receiver_no_stalls = 1'b0;
    endtask

    initial
    begin
        free_frame    = '0;
        hits_so_far   = '0;
        faults_so_far = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_lru_eviction();
        test_page_table_fill();
        test_output_backpressure();
        test_random_locality(1510);

        if (s_tvalid)
            s_tvalid <= 1'b0;
        wait (pending_translations.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/tlbpt_pkg.sv
design/tlbpt_cell.sv
design/tlbpt_page_table.sv
design/tlb_page_table_translator_top.sv
dv/tlb_page_table_translator_top_tb.sv
